[design/fbds_pkg.sv]
// fbds_pkg: shared constants, register indexes and transaction types
// for the framebuffer downscaler; no dependencies
package fbds_pkg;

	// display and source size limits
	localparam int DISP_MAX = 1024;
	localparam int SRC_MAX  = 4096;

	// field widths
	localparam int COLOR_W    = 16;
	localparam int ADDR_W     = 20;
	localparam int DEST_W     = 11;
	localparam int DISP_W     = 11;
	localparam int SRC_W      = 13;
	localparam int SCALE_W    = 8;
	localparam int POS_W      = 12;
	localparam int COORD_W    = $clog2(DISP_MAX);
	localparam int CFG_DATA_W = 13;
	localparam int REG_IDX_W  = 3;
	localparam int DIV_W      = 14;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_DEST_X       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEST_Y       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DISP_WIDTH   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DISP_HEIGHT  = 3'd6;

	// saturation point of the display position counters
	localparam logic signed [POS_W-1:0] TARGET_CAP = 12'sd2047;

	// geometry seen by the front end, sizes already clamped
	typedef struct packed {
		logic [DEST_W-1:0]  dest_x;
		logic [DEST_W-1:0]  dest_y;
		logic [SRC_W-1:0]   src_w;
		logic [SRC_W-1:0]   src_h;
		logic [DISP_W-1:0]  disp_w;
		logic [DISP_W-1:0]  disp_h;
		logic [SCALE_W-1:0] scale;
	} cfg_t;

	// one kept pixel on its way from front to back
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [COLOR_W-1:0] color;
	} pix_t;

endpackage

[design/framebuffer_integer_downscaler_unit.sv]
// framebuffer_integer_downscaler_unit: top level of the nearest-neighbour downscaler
// depends on fbds_pkg, fbds_fifo, fbds_div, fbds_front, fbds_back
//
// channel   | handshake        | payload
// ----------+------------------+-------------------------------
// pixel in  | push / full      | pixel_color, frame_start
// write out | pop / empty      | write_address, write_color
// config    | cfg_we (no wait) | cfg_index, cfg_data
//
// One source pixel per cycle is taken while full is low; a kept pixel reaches the
// result queue through a two-entry queue and the address multiply.
// After a register write, full stays high while the divider
// works out the automatic scale, one quotient bit a cycle.
// Reset leaves all registers at their reset values and the block ready at once.
// A stalled result side fills both queues, then raises full.
module framebuffer_integer_downscaler_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [fbds_pkg::COLOR_W-1:0]    pixel_color,
	input  logic                            frame_start,
	output logic                            empty,
	input  logic                            pop,
	output logic [fbds_pkg::ADDR_W-1:0]     write_address,
	output logic [fbds_pkg::COLOR_W-1:0]    write_color,
	input  logic                            cfg_we,
	input  logic [fbds_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [fbds_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int PIX_W = $bits(fbds_pkg::pix_t);
	localparam int OUT_W = fbds_pkg::ADDR_W + fbds_pkg::COLOR_W;

	logic [fbds_pkg::DEST_W-1:0]  dest_x_q, dest_y_q;
	logic [fbds_pkg::SRC_W-1:0]   src_width_q, src_height_q;
	logic [fbds_pkg::SCALE_W-1:0] scale_factor_q, auto_scale;
	logic [fbds_pkg::DISP_W-1:0]  disp_width_q, disp_height_q;
	logic                         cfg_valid, start_q, div_busy, busy;
	fbds_pkg::cfg_t               cfg;
	logic [fbds_pkg::DIV_W-1:0]   dividend;
	logic                         accept, keep;
	fbds_pkg::pix_t               front_pix, mid_pix;
	logic [PIX_W-1:0]             mid_rdata;
	logic                         mid_full, mid_empty, mid_pop, out_push, out_full;
	logic [fbds_pkg::ADDR_W-1:0]  back_addr;
	logic [fbds_pkg::COLOR_W-1:0] back_color;
	logic [OUT_W-1:0]             out_rdata;

	assign cfg_valid = cfg_we && (cfg_index == fbds_pkg::REG_DEST_X
		|| cfg_index == fbds_pkg::REG_DEST_Y || cfg_index == fbds_pkg::REG_SRC_WIDTH
		|| cfg_index == fbds_pkg::REG_SRC_HEIGHT || cfg_index == fbds_pkg::REG_SCALE_FACTOR
		|| cfg_index == fbds_pkg::REG_DISP_WIDTH || cfg_index == fbds_pkg::REG_DISP_HEIGHT);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q       <= '0;
			dest_y_q       <= '0;
			src_width_q    <= 13'd320;
			src_height_q   <= 13'd240;
			scale_factor_q <= 8'd1;
			disp_width_q   <= 11'd320;
			disp_height_q  <= 11'd240;
			start_q        <= 1'b0;
		end else begin
			start_q <= cfg_valid;
			if (cfg_we) begin
				unique case (cfg_index)
					fbds_pkg::REG_DEST_X:       dest_x_q <= cfg_data[fbds_pkg::DEST_W-1:0];
					fbds_pkg::REG_DEST_Y:       dest_y_q <= cfg_data[fbds_pkg::DEST_W-1:0];
					fbds_pkg::REG_SRC_WIDTH:    src_width_q <= cfg_data;
					fbds_pkg::REG_SRC_HEIGHT:   src_height_q <= cfg_data;
					fbds_pkg::REG_SCALE_FACTOR: scale_factor_q <= cfg_data[fbds_pkg::SCALE_W-1:0];
					fbds_pkg::REG_DISP_WIDTH:   disp_width_q <= cfg_data[fbds_pkg::DISP_W-1:0];
					fbds_pkg::REG_DISP_HEIGHT:  disp_height_q <= cfg_data[fbds_pkg::DISP_W-1:0];
					default:                    ;
				endcase
			end
		end
	end

	// clamped geometry and effective scale
	always_comb begin
		cfg.dest_x = dest_x_q;
		cfg.dest_y = dest_y_q;
		cfg.src_w  = (src_width_q > fbds_pkg::SRC_W'(fbds_pkg::SRC_MAX))
			? fbds_pkg::SRC_W'(fbds_pkg::SRC_MAX) : src_width_q;
		cfg.src_h  = (src_height_q > fbds_pkg::SRC_W'(fbds_pkg::SRC_MAX))
			? fbds_pkg::SRC_W'(fbds_pkg::SRC_MAX) : src_height_q;
		cfg.disp_w = (disp_width_q > fbds_pkg::DISP_W'(fbds_pkg::DISP_MAX))
			? fbds_pkg::DISP_W'(fbds_pkg::DISP_MAX) : disp_width_q;
		cfg.disp_h = (disp_height_q > fbds_pkg::DISP_W'(fbds_pkg::DISP_MAX))
			? fbds_pkg::DISP_W'(fbds_pkg::DISP_MAX) : disp_height_q;
		cfg.scale  = (scale_factor_q != '0) ? scale_factor_q : auto_scale;
		dividend   = {1'b0, src_width_q} + fbds_pkg::DIV_W'(cfg.disp_w) - 1'b1;
	end

	// automatic scale, ceiling of source width over display width
	fbds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (dividend),
		.divisor  (cfg.disp_w),
		.busy     (div_busy),
		.quot     (auto_scale)
	);

	assign busy   = start_q || div_busy;
	assign full   = mid_full || busy;
	assign accept = push && !full;

	// front end: counters and classification
	fbds_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.restart     (start_q),
		.accept      (accept),
		.pixel_color (pixel_color),
		.frame_start (frame_start),
		.keep        (keep),
		.pix         (front_pix)
	);

	// queue between front and back
	fbds_fifo #(
		.WIDTH (PIX_W),
		.DEPTH (2)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (keep),
		.wdata  (front_pix),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign mid_pix = mid_rdata;

	// back end: framebuffer address
	fbds_back u_back (
		.pix       (mid_pix),
		.mid_empty (mid_empty),
		.out_full  (out_full),
		.disp_w    (cfg.disp_w),
		.mid_pop   (mid_pop),
		.out_push  (out_push),
		.addr      (back_addr),
		.color     (back_color)
	);

	// result queue
	fbds_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (2)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  ({back_addr, back_color}),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign write_address = out_rdata[OUT_W-1:fbds_pkg::COLOR_W];
	assign write_color   = out_rdata[fbds_pkg::COLOR_W-1:0];

	// a kept pixel is never offered to a full queue
	assert property (@(posedge clk) disable iff (!arst_n) keep |-> !mid_full)
		else $error("kept pixel pushed into full queue");

	// a register write holds off pixels while the scale is worked out
	assert property (@(posedge clk) disable iff (!arst_n) cfg_valid |=> full ##1 full)
		else $error("pixel input open right after register write");

	// the effective scale is never zero
	assert property (@(posedge clk) disable iff (!arst_n) !busy |-> cfg.scale != '0)
		else $error("zero effective scale");

	// the back end moves a transaction only into a queue with room
	assert property (@(posedge clk) disable iff (!arst_n) out_push |-> !out_full && !mid_empty)
		else $error("back end transfer without room");

endmodule

[design/fbds_fifo.sv]
// fbds_fifo: small register queue with push/full and pop/empty sides
// generic payload; no package dependency
module fbds_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/fbds_div.sv]
// fbds_div: restoring divider, one quotient bit a cycle, for the automatic scale
// uses fbds_pkg for widths
module fbds_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fbds_pkg::DIV_W-1:0]   dividend,
	input  logic [fbds_pkg::DISP_W-1:0]  divisor,
	output logic                         busy,
	output logic [fbds_pkg::SCALE_W-1:0] quot
);
	localparam int CNT_W = $clog2(fbds_pkg::DIV_W);

	logic                         run_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [fbds_pkg::DIV_W-1:0]   dvd_q, dvd_nx;
	logic [fbds_pkg::DISP_W-1:0]  div_q, rem_q, rem_nx;
	logic [fbds_pkg::DISP_W:0]    rem_sh, rem_sub;
	logic                         ge;
	logic [fbds_pkg::SCALE_W-1:0] quot_q, quot_sat;

	// one restoring step
	always_comb begin
		rem_sh  = {rem_q, dvd_q[fbds_pkg::DIV_W-1]};
		ge      = rem_sh >= {1'b0, div_q};
		rem_sub = rem_sh - {1'b0, div_q};
		rem_nx  = ge ? rem_sub[fbds_pkg::DISP_W-1:0] : rem_sh[fbds_pkg::DISP_W-1:0];
		dvd_nx  = {dvd_q[fbds_pkg::DIV_W-2:0], ge};
	end

	// saturate to the scale range, never below one
	always_comb begin
		priority if (dvd_nx[fbds_pkg::DIV_W-1:fbds_pkg::SCALE_W] != '0) begin
			quot_sat = '1;
		end else if (dvd_nx[fbds_pkg::SCALE_W-1:0] == '0) begin
			quot_sat = fbds_pkg::SCALE_W'(1);
		end else begin
			quot_sat = dvd_nx[fbds_pkg::SCALE_W-1:0];
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			quot_q <= fbds_pkg::SCALE_W'(1);
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(fbds_pkg::DIV_W - 1)) begin
				run_q  <= 1'b0;
				quot_q <= quot_sat;
			end
		end
	end

	// operand registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
		end
	end

	assign busy = run_q;
	assign quot = quot_q;

endmodule

[design/fbds_front.sv]
// fbds_front: position and phase counters, classifies each source pixel
// as kept or dropped; uses fbds_pkg
module fbds_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fbds_pkg::cfg_t               cfg,
	input  logic                         restart,
	input  logic                         accept,
	input  logic [fbds_pkg::COLOR_W-1:0] pixel_color,
	input  logic                         frame_start,
	output logic                         keep,
	output fbds_pkg::pix_t               pix
);
	localparam int PW = fbds_pkg::POS_W;
	localparam int HW = fbds_pkg::SCALE_W;

	logic [PW-1:0]        col_q, row_q, col_c, row_c;
	logic [HW-1:0]        cph_q, rph_q, cph_c, rph_c;
	logic signed [PW-1:0] tcol_q, trow_q, tcol_c, trow_c;
	logic signed [PW-1:0] org_x, org_y;
	logic                 col_last, row_last, cph_wrap, rph_wrap;

	assign org_x = {cfg.dest_x[fbds_pkg::DEST_W-1], cfg.dest_x};
	assign org_y = {cfg.dest_y[fbds_pkg::DEST_W-1], cfg.dest_y};

	// current position, taken from the frame origin on a frame start
	always_comb begin
		if (frame_start) begin
			col_c  = '0;
			row_c  = '0;
			cph_c  = '0;
			rph_c  = '0;
			tcol_c = org_x;
			trow_c = org_y;
		end else begin
			col_c  = col_q;
			row_c  = row_q;
			cph_c  = cph_q;
			rph_c  = rph_q;
			tcol_c = tcol_q;
			trow_c = trow_q;
		end
	end

	// inside-display test and kept pixel
	always_comb begin
		keep = accept && !tcol_c[PW-1] && !trow_c[PW-1]
			&& (tcol_c[fbds_pkg::DISP_W-1:0] < cfg.disp_w)
			&& (trow_c[fbds_pkg::DISP_W-1:0] < cfg.disp_h);
		pix.row   = trow_c[fbds_pkg::COORD_W-1:0];
		pix.col   = tcol_c[fbds_pkg::COORD_W-1:0];
		pix.color = pixel_color;
	end

	// end of row, end of frame and end of block
	always_comb begin
		col_last = ({1'b0, col_c} + 13'd1) >= cfg.src_w;
		row_last = ({1'b0, row_c} + 13'd1) >= cfg.src_h;
		cph_wrap = ({1'b0, cph_c} + 9'd1) >= {1'b0, cfg.scale};
		rph_wrap = ({1'b0, rph_c} + 9'd1) >= {1'b0, cfg.scale};
	end

	// counter update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
			tcol_q <= '0;
			trow_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
			tcol_q <= org_x;
			trow_q <= org_y;
		end else if (accept) begin
			if (col_last) begin
				col_q  <= '0;
				cph_q  <= '0;
				tcol_q <= org_x;
				if (row_last) begin
					row_q  <= '0;
					rph_q  <= '0;
					trow_q <= org_y;
				end else begin
					row_q <= row_c + 1'b1;
					if (rph_wrap) begin
						rph_q  <= '0;
						trow_q <= (trow_c == fbds_pkg::TARGET_CAP) ? trow_c : trow_c + PW'(1);
					end else begin
						rph_q  <= rph_c + 1'b1;
						trow_q <= trow_c;
					end
				end
			end else begin
				col_q  <= col_c + 1'b1;
				row_q  <= row_c;
				rph_q  <= rph_c;
				trow_q <= trow_c;
				if (cph_wrap) begin
					cph_q  <= '0;
					tcol_q <= (tcol_c == fbds_pkg::TARGET_CAP) ? tcol_c : tcol_c + PW'(1);
				end else begin
					cph_q  <= cph_c + 1'b1;
					tcol_q <= tcol_c;
				end
			end
		end
	end

endmodule

[design/fbds_back.sv]
// fbds_back: turns a kept pixel into a framebuffer write (row * width + column)
// uses fbds_pkg; feeds the result queue
module fbds_back (
	input  fbds_pkg::pix_t               pix,
	input  logic                         mid_empty,
	input  logic                         out_full,
	input  logic [fbds_pkg::DISP_W-1:0]  disp_w,
	output logic                         mid_pop,
	output logic                         out_push,
	output logic [fbds_pkg::ADDR_W-1:0]  addr,
	output logic [fbds_pkg::COLOR_W-1:0] color
);
	localparam int PROD_W = fbds_pkg::COORD_W + fbds_pkg::DISP_W;

	logic [PROD_W-1:0] prod;
	logic [PROD_W:0]   sum;

	// move one transaction whenever both queues allow it
	assign mid_pop  = !mid_empty && !out_full;
	assign out_push = mid_pop;

	// address; registered by the result queue
	always_comb begin
		prod  = PROD_W'(pix.row) * PROD_W'(disp_w);
		sum   = {1'b0, prod} + (PROD_W + 1)'(pix.col);
		addr  = sum[fbds_pkg::ADDR_W-1:0];
		color = pix.color;
	end

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for framebuffer_integer_downscaler_unit
// depends on fbds_pkg and the downscaler RTL; predicts every framebuffer write
// and checks each popped transaction against the oldest prediction
module tb_top;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 8;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [fbds_pkg::ADDR_W-1:0]  addr;
		logic [fbds_pkg::COLOR_W-1:0] color;
	} fb_write_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            push = 1'b0;
	logic                            full;
	logic [fbds_pkg::COLOR_W-1:0]    pixel_color = '0;
	logic                            frame_start = 1'b0;
	logic                            empty;
	logic                            pop = 1'b0;
	logic [fbds_pkg::ADDR_W-1:0]     write_address;
	logic [fbds_pkg::COLOR_W-1:0]    write_color;
	logic                            cfg_we = 1'b0;
	logic [fbds_pkg::REG_IDX_W-1:0]  cfg_index = '0;
	logic [fbds_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// bench copy of the geometry registers
	logic [fbds_pkg::DEST_W-1:0]  geom_dest_x, geom_dest_y;
	logic [fbds_pkg::SRC_W-1:0]   geom_src_w, geom_src_h;
	logic [fbds_pkg::SCALE_W-1:0] geom_scale;
	logic [fbds_pkg::DISP_W-1:0]  geom_disp_w, geom_disp_h;

	// bench copy of the scan position
	int src_col, src_row, col_phase, row_phase, eff_scale, tgt_col, tgt_row;

	fb_write_t pending_writes[$];
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        send_idle_pct = 0;
	int        rx_stall_pct = 0;
	int        rx_hold_target = 0;
	int        rx_held = 0;

	framebuffer_integer_downscaler_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.pixel_color   (pixel_color),
		.frame_start   (frame_start),
		.empty         (empty),
		.pop           (pop),
		.write_address (write_address),
		.write_color   (write_color),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int clip(int v, int hi);
		return (v > hi) ? hi : v;
	endfunction

	// scale in use: automatic ceil(src/disp) when the register is zero
	function automatic void refresh_scale();
		int s, dw;
		s = geom_scale;
		dw = clip(geom_disp_w, fbds_pkg::DISP_MAX);
		if (s == 0)
			s = (dw == 0) ? 255 : clip((geom_src_w + dw - 1) / dw, 255);
		eff_scale = (s < 1) ? 1 : s;
	endfunction

	function automatic void restart_scan();
		refresh_scale();
		src_col = 0;
		src_row = 0;
		col_phase = 0;
		row_phase = 0;
		tgt_col = $signed(geom_dest_x);
		tgt_row = $signed(geom_dest_y);
	endfunction

	function automatic int bump(int t);
		return (t >= fbds_pkg::TARGET_CAP) ? fbds_pkg::TARGET_CAP : t + 1;
	endfunction

	// register write; every write to a defined register restarts the scan
	function automatic void store_reg(logic [fbds_pkg::REG_IDX_W-1:0] idx,
			logic [fbds_pkg::CFG_DATA_W-1:0] d);
		case (idx)
			fbds_pkg::REG_DEST_X:       geom_dest_x = d[fbds_pkg::DEST_W-1:0];
			fbds_pkg::REG_DEST_Y:       geom_dest_y = d[fbds_pkg::DEST_W-1:0];
			fbds_pkg::REG_SRC_WIDTH:    geom_src_w  = d[fbds_pkg::SRC_W-1:0];
			fbds_pkg::REG_SRC_HEIGHT:   geom_src_h  = d[fbds_pkg::SRC_W-1:0];
			fbds_pkg::REG_SCALE_FACTOR: geom_scale  = d[fbds_pkg::SCALE_W-1:0];
			fbds_pkg::REG_DISP_WIDTH:   geom_disp_w = d[fbds_pkg::DISP_W-1:0];
			fbds_pkg::REG_DISP_HEIGHT:  geom_disp_h = d[fbds_pkg::DISP_W-1:0];
			default: return;
		endcase
		restart_scan();
	endfunction

	// one source pixel: queue its framebuffer write if it lands on the display
	function automatic void map_pixel(logic [fbds_pkg::COLOR_W-1:0] color, logic fs);
		int dw, dh, sw, sh, a;
		fb_write_t w;
		dw = clip(geom_disp_w, fbds_pkg::DISP_MAX);
		dh = clip(geom_disp_h, fbds_pkg::DISP_MAX);
		sw = clip(geom_src_w, fbds_pkg::SRC_MAX);
		sh = clip(geom_src_h, fbds_pkg::SRC_MAX);
		if (fs)
			restart_scan();
		if (tgt_col >= 0 && tgt_row >= 0 && tgt_col < dw && tgt_row < dh) begin
			a = tgt_row * dw + tgt_col;
			w.addr = a[fbds_pkg::ADDR_W-1:0];
			w.color = color;
			pending_writes.push_back(w);
		end
		if (src_col + 1 >= sw) begin
			src_col = 0;
			col_phase = 0;
			tgt_col = $signed(geom_dest_x);
			if (src_row + 1 >= sh) begin
				restart_scan();
			end else begin
				src_row++;
				if (row_phase + 1 >= eff_scale) begin
					row_phase = 0;
					tgt_row = bump(tgt_row);
				end else begin
					row_phase++;
				end
			end
		end else begin
			src_col++;
			if (col_phase + 1 >= eff_scale) begin
				col_phase = 0;
				tgt_col = bump(tgt_col);
			end else begin
				col_phase++;
			end
		end
	endfunction

	// result side: random stalls, plus a counted hold-off when asked
	always @(posedge clk) begin
		if (rx_held < rx_hold_target) begin
			rx_held++;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// compare each popped transaction with the oldest prediction
	always @(posedge clk) begin
		fb_write_t want;
		if (arst_n && pop && !empty) begin
			if (pending_writes.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected write: addr %h colour %h", write_address, write_color);
				mismatches++;
			end else begin
				want = pending_writes.pop_front();
				if (write_address !== want.addr || write_color !== want.color) begin
					if (mismatches < 10)
						$display("write mismatch: expected addr %h colour %h, got addr %h colour %h",
							want.addr, want.color, write_address, write_color);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin send_idle_pct = 0;  rx_stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 70; rx_stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  rx_stall_pct = 70; end
			IDLE_BOTH:     begin send_idle_pct = 14; rx_stall_pct = 14; end
		endcase
	endtask

	// offer one pixel until taken; push is left high for the next one
	task automatic send_pixel(input logic [fbds_pkg::COLOR_W-1:0] color, input logic fs);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		push <= 1'b1;
		pixel_color <= color;
		frame_start <= fs;
		do
			@(posedge clk);
		while (full);
		map_pixel(color, fs);
	endtask

	// stop offering and wait for every predicted write, then let the pipe settle
	task automatic drain_writes();
		push <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fbds_pkg::REG_IDX_W-1:0] idx, input int v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[fbds_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		store_reg(idx, v[fbds_pkg::CFG_DATA_W-1:0]);
	endtask

	task automatic program_geometry(input int dx, input int dy, input int sw, input int sh,
			input int sc, input int dw, input int dh);
		drain_writes();
		write_reg(fbds_pkg::REG_DEST_X, dx);
		write_reg(fbds_pkg::REG_DEST_Y, dy);
		write_reg(fbds_pkg::REG_SRC_WIDTH, sw);
		write_reg(fbds_pkg::REG_SRC_HEIGHT, sh);
		write_reg(fbds_pkg::REG_SCALE_FACTOR, sc);
		write_reg(fbds_pkg::REG_DISP_WIDTH, dw);
		write_reg(fbds_pkg::REG_DISP_HEIGHT, dh);
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	function automatic int pick_origin();
		case ($urandom_range(9))
			0: return -1024;
			1: return 1023;
			2: return int'($urandom_range(2047)) - 1024;
			default: return int'($urandom_range(6)) - 3;
		endcase
	endfunction

	function automatic int pick_src();
		case ($urandom_range(19))
			0: return 0;
			1: return 8191;
			2: return 4096;
			3: return $urandom_range(1, 4096);
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic int pick_disp();
		case ($urandom_range(19))
			0: return 0;
			1: return 2047;
			2: return 1024;
			3: return $urandom_range(1, 1024);
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	// reset values straight out of reset, first pixel without frame start
	task automatic test_reset_defaults();
		set_idling(IDLE_NONE);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hFFFF, 1'b1);
	endtask

	// far corner of the largest display, oversized width register
	task automatic test_corner_address();
		set_idling(IDLE_NONE);
		program_geometry(1023, 1023, 2, 2, 1, 2047, 1024);
		send_pixel(16'hFFFF, 1'b1);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'h8001, 1'b0);
	endtask

	// origin left of and above the display
	task automatic test_negative_origin();
		set_idling(IDLE_NONE);
		program_geometry(-1, 0, 3, 1, 1, 4, 4);
		send_pixel(16'h5555, 1'b1);
		send_pixel(16'hAAAA, 1'b0);
		send_pixel(16'h1234, 1'b0);
		program_geometry(-1024, -1024, 2, 2, 1, 4, 4);
		send_pixel(16'hFFFF, 1'b1);
		send_pixel(16'h0001, 1'b0);
	endtask

	// automatic scale, then automatic scale with a zero-width display
	task automatic test_auto_scale();
		set_idling(IDLE_NONE);
		program_geometry(0, 0, 10, 4, 0, 3, 3);
		for (int i = 0; i < 6; i++)
			send_pixel(16'($urandom_range(16'hFFFF)), i == 0);
		program_geometry(0, 0, 10, 4, 0, 0, 3);
		send_pixel(16'hF00F, 1'b1);
		send_pixel(16'h0FF0, 1'b0);
	endtask

	// zero-sized source ends every row and frame; oversized source with top scale
	task automatic test_degenerate_source();
		set_idling(IDLE_NONE);
		program_geometry(2, 1, 0, 0, 2, 8, 8);
		send_pixel(16'h7BEF, 1'b0);
		send_pixel(16'h8410, 1'b0);
		send_pixel(16'hC618, 1'b1);
		program_geometry(0, 0, 8191, 8191, 255, 8, 8);
		send_pixel(16'h39E7, 1'b1);
		send_pixel(16'hFFFE, 1'b0);
	endtask

	// long row from the right edge drives the column counter into saturation
	task automatic test_target_saturation();
		set_idling(IDLE_NONE);
		program_geometry(1023, 0, 4096, 1, 1, 1024, 1024);
		for (int i = 0; i < 1040; i++)
			send_pixel(16'($urandom_range(16'hFFFF)), i == 0);
	endtask

	// result side held off so that input stalls, then a full pause by the sender
	task automatic test_backpressure();
		set_idling(IDLE_NONE);
		program_geometry(0, 0, 8, 8, 1, 64, 64);
		rx_hold_target = rx_hold_target + HOLD_CYCLES;
		for (int i = 0; i < 60; i++)
			send_pixel(16'($urandom_range(16'hFFFF)), i == 0);
		drain_writes();
		for (int i = 0; i < 20; i++)
			send_pixel(16'($urandom_range(16'hFFFF)), 1'b0);
	endtask

	// random geometries; mostly whole frames, some cut short, some noise
	task automatic test_random_traffic();
		idle_mode_t modes[4] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
		int left, n, flen, kind, sc;
		foreach (modes[m]) begin
			set_idling(modes[m]);
			repeat (5) begin
				case ($urandom_range(9))
					0, 1: sc = 0;
					2: sc = 255;
					3: sc = $urandom_range(255);
					default: sc = $urandom_range(1, 4);
				endcase
				program_geometry(pick_origin(), pick_origin(), pick_src(), pick_src(), sc,
					pick_disp(), pick_disp());
				left = 20;
				while (left > 0) begin
					flen = ((geom_src_w == 0) ? 1 : clip(geom_src_w, fbds_pkg::SRC_MAX)) *
						((geom_src_h == 0) ? 1 : clip(geom_src_h, fbds_pkg::SRC_MAX));
					flen = clip(flen, left);
					kind = $urandom_range(99);
					if (kind < 80) begin
						n = flen;
						for (int i = 0; i < n; i++)
							send_pixel(16'($urandom_range(16'hFFFF)), i == 0);
					end else if (kind < 90) begin
						n = $urandom_range(1, flen);
						for (int i = 0; i < n; i++)
							send_pixel(16'($urandom_range(16'hFFFF)), i == 0);
					end else begin
						n = $urandom_range(1, clip(8, left));
						for (int i = 0; i < n; i++)
							send_pixel(16'($urandom_range(16'hFFFF)), $urandom_range(3) == 0);
					end
					left -= n;
				end
			end
		end
	endtask

	initial begin
		geom_dest_x = '0;
		geom_dest_y = '0;
		geom_src_w = 13'd320;
		geom_src_h = 13'd240;
		geom_scale = 8'd1;
		geom_disp_w = 11'd320;
		geom_disp_h = 11'd240;
		restart_scan();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_corner_address();
		test_negative_origin();
		test_auto_scale();
		test_degenerate_source();
		test_target_saturation();
		test_backpressure();
		test_random_traffic();
		drain_writes();

		if (pending_writes.size() != 0)
			$display("writes never seen: %0d", pending_writes.size());
		if (mismatches == 0 && pending_writes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[framebuffer_integer_downscaler_unit.f]
design/fbds_pkg.sv
design/fbds_fifo.sv
design/fbds_div.sv
design/fbds_front.sv
design/fbds_back.sv
design/framebuffer_integer_downscaler_unit.sv
bench/tb_top.sv
